[hw/rtl/hslrgb_pkg.sv]
`default_nettype none

package hslrgb_pkg;

    localparam int unsigned HUE_W   = 14;
    localparam int unsigned FRAC_W  = 9;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned CN_W    = 17;
    localparam int unsigned TR_W    = 10;
    localparam int unsigned XP_W    = 26;
    localparam int unsigned BASE_W  = 18;
    localparam int unsigned NUM_W   = 27;
    localparam int unsigned PROD_W  = 35;
    localparam int unsigned QUOT_W  = 12;
    localparam int unsigned RCP_W   = 13;

    localparam logic [FRAC_W-1:0] FRAC_ONE   = 9'd256;
    localparam logic [12:0]       HUE_SECTOR = 13'd960;
    localparam logic [12:0]       HUE_FULL   = 13'd5760;
    // floor(v / 15) == (v * 4370) >> 16 for v below 4681
    localparam logic [RCP_W-1:0]  RECIP_15   = 13'd4370;
    localparam int unsigned       RECIP_SH   = 16;
    // 255 / (65536 * 960 * 2): >> 17, >> 6, then / 15
    localparam int unsigned       PROD_SH    = 23;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    typedef struct packed {
        logic en_mul;
        logic en_div;
    } scale_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/hslrgb_scale.sv]
`default_nettype none

module hslrgb_scale
    import hslrgb_pkg::*;
(
    input  wire logic                aclk,
    input  wire scale_ctrl_t         ctrl,
    input  wire logic [NUM_W-1:0]    num,
    output logic      [CHAN_W-1:0]   chan
);

    logic [PROD_W-1:0]        prod;
    logic [QUOT_W-1:0]        quot_reg;
    logic [QUOT_W+RCP_W-1:0]  recip;
    logic [CHAN_W-1:0]        chan_reg;

    // num * 255, then drop the power-of-two part of the denominator
    assign prod  = (PROD_W'(num) << 8) - PROD_W'(num);
    assign recip = (QUOT_W+RCP_W)'(quot_reg) * (QUOT_W+RCP_W)'(RECIP_15);

    always_ff @(posedge aclk) begin
        if (ctrl.en_mul) begin
            quot_reg <= prod[PROD_SH +: QUOT_W];
        end
        if (ctrl.en_div) begin
            chan_reg <= recip[RECIP_SH +: CHAN_W];
        end
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

[hw/rtl/hsl_to_rgb_converter_top.sv]
// HSL to RGB pixel converter. Hue comes in 1/16 degree (a negative hue or one of 360 degrees
// or more drops the chroma terms, so the pixel is gray at the offset level), saturation and lightness
// in units of 1/256 with anything above 256 taken as 1.0. Each channel is (component + offset)
// * 255 truncated toward zero. The block is a six-stage pipeline that takes one pixel every
// clock unless a result-side stall has filled it; the stages are the sector search, the chroma
// multiply, the secondary-component multiply, the channel sum, the * 255 scaling and the
// divide by 15 done as a reciprocal multiply. A stall on the result side holds only the full
// stages, so bubbles are squeezed out and requests keep entering while the output waits until the pipe is full.
`default_nettype none

module hsl_to_rgb_converter_top
    import hslrgb_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [HUE_W-1:0]  s_hue,
    input  wire logic [FRAC_W-1:0]        s_saturation,
    input  wire logic [FRAC_W-1:0]        s_lightness,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [CHAN_W-1:0]             m_red,
    output logic [CHAN_W-1:0]             m_green,
    output logic [CHAN_W-1:0]             m_blue
);

    logic [6:1] vld_reg;
    logic [6:1] en;

    // stage 0 logic
    logic [FRAC_W-1:0] sat_c, lit_c;
    logic [FRAC_W:0]   twol, lit_dev;
    logic [FRAC_W-1:0] ampl;
    logic [12:0]       hu, hu_base;
    logic              hue_ok;
    sector_t           sec_next;
    logic [TR_W-1:0]   off, tr_next;

    // stage registers
    logic [FRAC_W-1:0] s1_reg, l1_reg, a1_reg, l2_reg;
    logic              ok1_reg, ok2_reg, ok3_reg;
    sector_t           sec1_reg, sec2_reg, sec3_reg;
    logic [TR_W-1:0]   tr1_reg, tr2_reg;
    logic [CN_W-1:0]   cn2_reg, cn3_reg;
    logic [XP_W-1:0]   xp3_reg;
    logic [BASE_W-1:0] base3_reg;
    logic [NUM_W-1:0]  nr4_reg, ng4_reg, nb4_reg;

    logic [CN_W-1:0]   cn_next;
    logic [XP_W-1:0]   xp_next;
    logic [BASE_W-1:0] base_next;
    logic [NUM_W:0]    mterm, cterm, xterm;
    logic [NUM_W:0]    r1, g1, b1;

    scale_ctrl_t scl_ctrl;

    // stall chain: a stage moves when it is empty or the next one moves
    assign en[6]   = !vld_reg[6] || m_ready;
    assign en[5]   = !vld_reg[5] || en[6];
    assign en[4]   = !vld_reg[4] || en[5];
    assign en[3]   = !vld_reg[3] || en[4];
    assign en[2]   = !vld_reg[2] || en[3];
    assign en[1]   = !vld_reg[1] || en[2];
    assign s_ready = en[1];
    assign m_valid = vld_reg[6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[1]) vld_reg[1] <= s_valid;
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
            if (en[4]) vld_reg[4] <= vld_reg[3];
            if (en[5]) vld_reg[5] <= vld_reg[4];
            if (en[6]) vld_reg[6] <= vld_reg[5];
        end
    end

    // clamp fractions, chroma amplitude, sector search
    always_comb begin
        sat_c = (s_saturation > FRAC_ONE) ? FRAC_ONE : s_saturation;
        lit_c = (s_lightness > FRAC_ONE) ? FRAC_ONE : s_lightness;
        twol  = {lit_c, 1'b0};
        lit_dev = (twol >= 10'(FRAC_ONE)) ? twol - 10'(FRAC_ONE) : 10'(FRAC_ONE) - twol;
        ampl  = FRAC_ONE - lit_dev[FRAC_W-1:0];
        hu     = s_hue[12:0];
        hue_ok = !s_hue[HUE_W-1] && (hu < HUE_FULL);
        priority if (hu < HUE_SECTOR) begin
            sec_next = SEC_RED_YEL;
            hu_base  = 13'd0;
        end else if (hu < 13'(2 * HUE_SECTOR)) begin
            sec_next = SEC_YEL_GRN;
            hu_base  = 13'(HUE_SECTOR);
        end else if (hu < 13'(3 * HUE_SECTOR)) begin
            sec_next = SEC_GRN_CYN;
            hu_base  = 13'(2 * HUE_SECTOR);
        end else if (hu < 13'(4 * HUE_SECTOR)) begin
            sec_next = SEC_CYN_BLU;
            hu_base  = 13'(3 * HUE_SECTOR);
        end else if (hu < 13'(5 * HUE_SECTOR)) begin
            sec_next = SEC_BLU_MAG;
            hu_base  = 13'(4 * HUE_SECTOR);
        end else begin
            sec_next = SEC_MAG_RED;
            hu_base  = 13'(5 * HUE_SECTOR);
        end
        off = TR_W'(hu - hu_base);
        // odd sectors fall along the triangle
        tr_next = sec_next[0] ? TR_W'(HUE_SECTOR) - off : off;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s1_reg   <= sat_c;
            l1_reg   <= lit_c;
            a1_reg   <= ampl;
            ok1_reg  <= hue_ok;
            sec1_reg <= sec_next;
            tr1_reg  <= tr_next;
        end
    end

    assign cn_next = CN_W'(a1_reg) * CN_W'(s1_reg);

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            cn2_reg  <= cn_next;
            l2_reg   <= l1_reg;
            ok2_reg  <= ok1_reg;
            sec2_reg <= sec1_reg;
            tr2_reg  <= tr1_reg;
        end
    end

    assign xp_next   = XP_W'(cn2_reg) * XP_W'(tr2_reg);
    assign base_next = {l2_reg, 9'b0} - BASE_W'(cn2_reg);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            cn3_reg   <= cn2_reg;
            xp3_reg   <= xp_next;
            base3_reg <= base_next;
            ok3_reg   <= ok2_reg;
            sec3_reg  <= sec2_reg;
        end
    end

    // everything over 65536 * 960 * 2
    always_comb begin
        mterm = ((NUM_W+1)'(base3_reg) << 10) - ((NUM_W+1)'(base3_reg) << 6);
        cterm = ((NUM_W+1)'(cn3_reg) << 11) - ((NUM_W+1)'(cn3_reg) << 7);
        xterm = {1'b0, xp3_reg, 1'b0};
        r1 = '0;
        g1 = '0;
        b1 = '0;
        if (ok3_reg) begin
            unique case (sec3_reg)
                SEC_RED_YEL: begin
                    r1 = cterm;
                    g1 = xterm;
                end
                SEC_YEL_GRN: begin
                    r1 = xterm;
                    g1 = cterm;
                end
                SEC_GRN_CYN: begin
                    g1 = cterm;
                    b1 = xterm;
                end
                SEC_CYN_BLU: begin
                    g1 = xterm;
                    b1 = cterm;
                end
                SEC_BLU_MAG: begin
                    r1 = xterm;
                    b1 = cterm;
                end
                default: begin
                    r1 = cterm;
                    b1 = xterm;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            nr4_reg <= NUM_W'(r1 + mterm);
            ng4_reg <= NUM_W'(g1 + mterm);
            nb4_reg <= NUM_W'(b1 + mterm);
        end
    end

    assign scl_ctrl.en_mul = en[5];
    assign scl_ctrl.en_div = en[6];

    hslrgb_scale u_scale_red (
        .aclk (aclk),
        .ctrl (scl_ctrl),
        .num  (nr4_reg),
        .chan (m_red)
    );

    hslrgb_scale u_scale_green (
        .aclk (aclk),
        .ctrl (scl_ctrl),
        .num  (ng4_reg),
        .chan (m_green)
    );

    hslrgb_scale u_scale_blue (
        .aclk (aclk),
        .ctrl (scl_ctrl),
        .num  (nb4_reg),
        .chan (m_blue)
    );

    // a free output side never blocks the input
    a_ready_follows: assert property (@(posedge aclk) m_ready |-> s_ready)
        else $error("input stalled while output side is free");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // offset numerator never goes negative
    a_offset_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> (BASE_W'(cn2_reg) <= {l2_reg, 9'b0}))
        else $error("chroma exceeds twice the lightness");

    // a stalled result stays valid at the output stage until it is taken
    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[6] && !m_ready) |=> vld_reg[6])
        else $error("stalled result dropped");

endmodule

`default_nettype wire

[verif/hsl_to_rgb_converter_top_test.sv]
`default_nettype none

module hsl_to_rgb_converter_top_test
    import hslrgb_pkg::*;
();

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int BURST_PIXELS    = 40;
    localparam int RANDOM_PIXELS   = 1790;
    localparam int DRAIN_CYCLES    = 20;
    localparam longint unsigned SCALE_DENOM = 64'd125829120;   // 65536 * 960 * 2

    typedef struct {
        int unsigned       id;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_pixel_t;

    class rgb_scoreboard;
        rgb_pixel_t  expected_pixels[$];
        int unsigned requests_seen;
        int unsigned mismatches;

        function logic [CHAN_W-1:0] to_channel(longint unsigned num);
            return CHAN_W'((num * 255) / SCALE_DENOM);
        endfunction

        function rgb_pixel_t predict_rgb(logic signed [HUE_W-1:0] hue,
                                         logic [FRAC_W-1:0] sat,
                                         logic [FRAC_W-1:0] lit);
            longint unsigned s, l, twol, lit_dev, cn, mnum, cnum, xnum;
            longint unsigned rn, gn, bn, hp, tr;
            int              h;
            rgb_pixel_t      px;
            s = (sat > FRAC_ONE) ? FRAC_ONE : sat;
            l = (lit > FRAC_ONE) ? FRAC_ONE : lit;
            twol = 2 * l;
            lit_dev = (twol >= 256) ? twol - 256 : 256 - twol;
            cn   = (256 - lit_dev) * s;
            mnum = (512 * l - cn) * 960;
            cnum = cn * 1920;
            rn = 0;
            gn = 0;
            bn = 0;
            h  = hue;
            // hue off the circle leaves gray at the offset level
            if (h >= 0 && h < int'(HUE_FULL)) begin
                hp   = h % (2 * int'(HUE_SECTOR));
                tr   = (hp >= HUE_SECTOR) ? 2 * HUE_SECTOR - hp : hp;
                xnum = cn * tr * 2;
                case (sector_t'(h / int'(HUE_SECTOR)))
                    SEC_RED_YEL: begin rn = cnum; gn = xnum; end
                    SEC_YEL_GRN: begin rn = xnum; gn = cnum; end
                    SEC_GRN_CYN: begin gn = cnum; bn = xnum; end
                    SEC_CYN_BLU: begin gn = xnum; bn = cnum; end
                    SEC_BLU_MAG: begin rn = xnum; bn = cnum; end
                    default:     begin rn = cnum; bn = xnum; end
                endcase
            end
            px.id    = requests_seen;
            px.red   = to_channel(rn + mnum);
            px.green = to_channel(gn + mnum);
            px.blue  = to_channel(bn + mnum);
            return px;
        endfunction

        function void note_request(logic signed [HUE_W-1:0] hue,
                                   logic [FRAC_W-1:0] sat,
                                   logic [FRAC_W-1:0] lit);
            expected_pixels.push_back(predict_rgb(hue, sat, lit));
            requests_seen++;
        endfunction

        function int pixels_outstanding();
            return expected_pixels.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task check_pixel(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                         logic [CHAN_W-1:0] blue);
            rgb_pixel_t want;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %0d/%0d/%0d with no request pending",
                                          red, green, blue));
                return;
            end
            want = expected_pixels.pop_front();
            if (red !== want.red)
                report_mismatch($sformatf("request %0d red got %0d want %0d",
                                          want.id, red, want.red));
            if (green !== want.green)
                report_mismatch($sformatf("request %0d green got %0d want %0d",
                                          want.id, green, want.green));
            if (blue !== want.blue)
                report_mismatch($sformatf("request %0d blue got %0d want %0d",
                                          want.id, blue, want.blue));
        endtask
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [HUE_W-1:0]  s_hue;
    logic [FRAC_W-1:0]        s_saturation;
    logic [FRAC_W-1:0]        s_lightness;
    logic                     m_valid;
    logic                     m_ready;
    logic [CHAN_W-1:0]        m_red;
    logic [CHAN_W-1:0]        m_green;
    logic [CHAN_W-1:0]        m_blue;

    rgb_scoreboard sb = new();
    logic          hold_off_req = 1'b0;
    int            cycle_count = 0;

    hsl_to_rgb_converter_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_hue        (s_hue),
        .s_saturation (s_saturation),
        .s_lightness  (s_lightness),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return FRAC_W'($urandom_range(0, 256));
        else if (r < 85)
            return FRAC_W'($urandom_range(257, 511));
        else
            case ($urandom_range(0, 3))
                0: return 9'd0;
                1: return 9'd128;
                2: return FRAC_ONE;
                default: return 9'd511;
            endcase
    endfunction

    task automatic send_pixel(int hue, int sat, int lit);
        @(negedge aclk);
        s_valid      = 1'b1;
        s_hue        = HUE_W'(hue);
        s_saturation = FRAC_W'(sat);
        s_lightness  = FRAC_W'(lit);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_pixel();
        int hue;
        if ($urandom_range(0, 99) < 80)
            hue = $urandom_range(0, int'(HUE_FULL) - 1);
        else
            hue = $urandom_range(0, 16383);
        send_pixel(hue, int'(pick_fraction()), int'(pick_fraction()));
    endtask

    task automatic idle_sender(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid      = 1'b0;
            s_hue        = HUE_W'($urandom);
            s_saturation = FRAC_W'($urandom);
            s_lightness  = FRAC_W'($urandom);
        end
    endtask

    task automatic wait_drained();
        while (sb.pixels_outstanding() != 0) @(posedge aclk);
    endtask

    // request and result monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_request(s_hue, s_saturation, s_lightness);
            if (m_valid && m_ready)
                sb.check_pixel(m_red, m_green, m_blue);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int  chunk_left;
        int  stall_left;
        bit  stalls_on;
        m_ready    = 1'b0;
        chunk_left = 0;
        stall_left = 0;
        stalls_on  = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (chunk_left == 0) begin
                    chunk_left = $urandom_range(20, 200);
                    stalls_on  = ($urandom_range(0, 2) != 0);
                end
                chunk_left--;
                if (!stalls_on) begin
                    m_ready = 1'b1;
                end else if (stall_left > 0) begin
                    m_ready = 1'b0;
                    stall_left--;
                end else begin
                    stall_left = pick_gap();
                    m_ready = (stall_left == 0);
                    if (stall_left > 0)
                        stall_left--;
                end
            end
        end
    end

    initial begin
        bit gaps_on;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_hue        = '0;
        s_saturation = '0;
        s_lightness  = '0;
        gaps_on      = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // extremes, every sector, out-of-circle hue, clamped fractions
        send_pixel(0, 256, 128);
        send_pixel(959, 256, 128);
        send_pixel(960, 256, 128);
        send_pixel(1919, 256, 128);
        send_pixel(1920, 200, 100);
        send_pixel(2880, 256, 128);
        send_pixel(3840, 150, 180);
        send_pixel(4800, 256, 128);
        send_pixel(5759, 256, 128);
        send_pixel(5760, 256, 128);
        send_pixel(8191, 100, 200);
        send_pixel(-1, 256, 128);
        send_pixel(-8192, 256, 64);
        send_pixel(480, 0, 0);
        send_pixel(480, 256, 256);
        send_pixel(1440, 0, 77);
        send_pixel(2400, 511, 128);
        send_pixel(3360, 257, 300);
        send_pixel(4320, 511, 511);
        send_pixel(5280, 256, 1);
        send_pixel(720, 255, 255);
        send_pixel(3000, 1, 127);
        send_pixel(5000, 384, 0);
        send_pixel(2000, 256, 511);
        idle_sender(1);
        wait_drained();

        // receiver holds off while requests keep coming
        hold_off_req = 1'b1;
        repeat (BURST_PIXELS) send_random_pixel();
        idle_sender(1);
        wait_drained();

        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            if (i % 100 == 0)
                gaps_on = ($urandom_range(0, 2) != 0);
            if (gaps_on)
                idle_sender(pick_gap());
            send_random_pixel();
        end
        idle_sender(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/hslrgb_pkg.sv
hw/rtl/hslrgb_scale.sv
hw/rtl/hsl_to_rgb_converter_top.sv
verif/hsl_to_rgb_converter_top_test.sv
